FILE: sv/uuencode_line_encoder_defines.svh
// uuencode line encoder: assertion macros used by the checker file
// depends on nothing; included by bare file name
`ifndef UUENCODE_LINE_ENCODER_DEFINES_SVH
`define UUENCODE_LINE_ENCODER_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define ULE_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uuencode line encoder check failed");

// next-cycle implication, disabled while reset is high
`define ULE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uuencode line encoder check failed");

`endif

FILE: sv/ule_pkg.sv
// uuencode line encoder: shared constants, types and the character mapping
// no dependencies; imported by every module of the block
`default_nettype none

package ule_pkg;

   // line geometry
   localparam int LINE_BYTES = 45;
   localparam int NGROUPS    = (LINE_BYTES + 2) / 3;
   localparam int FILL_W     = $clog2(LINE_BYTES + 1);
   localparam int GRP_W      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;

   // characters
   localparam logic [6:0] ZERO_CHAR    = 7'h60;
   localparam logic [6:0] SPACE_CHAR   = 7'h20;
   localparam logic [6:0] NEWLINE_CHAR = 7'h0A;

   // result bus: out_char, char_total, line_total, one pad bit
   localparam int RSP_DATA_W = 72;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN,
      ST_CH0,
      ST_CH1,
      ST_CH2,
      ST_CH3,
      ST_NL
   } ule_state_type;

   typedef enum logic [1:0] {
      LEN_FULL,
      LEN_FILL,
      LEN_ZERO
   } ule_len_sel_type;

   typedef enum logic [2:0] {
      CHR_LEN,
      CHR_S0,
      CHR_S1,
      CHR_S2,
      CHR_S3,
      CHR_NL
   } ule_chr_sel_type;

   typedef struct packed {
      logic            store;      // write the incoming byte
      logic            fill_clear; // buffer restarts empty
      logic            len_load;   // load the length of the next line
      ule_len_sel_type len_sel;
      logic            grp_start;  // first group read, load bytes left
      logic            grp_next;   // advance to next group and read it
      logic            emit;       // load one character into the output register
      ule_chr_sel_type chr_sel;
      logic            last;       // final character of this transaction
   } ule_cmd_type;

   typedef struct packed {
      logic out_free;  // output register can take a character
      logic fill_top;  // one byte short of a full line
      logic fill_nz;   // buffer holds bytes
      logic len_zero;  // current line carries no bytes
      logic last_grp;  // current group is the last of the line
   } ule_status_type;

   // six-bit value to printable character
   function automatic logic [6:0] to_printable(input logic [5:0] v);
      logic [6:0] c;
      c = (v == 6'd0) ? ZERO_CHAR : ({1'b0, v} + SPACE_CHAR);
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: sv/uuencode_line_encoder.sv
// uuencode line encoder: top level joining controller and datapath
// depends on ule_pkg, ule_ctrl, ule_datapath
//
// Usage: raw bytes enter on the req_ stream, one per transaction (req_tuser
// high marks a valid byte, req_tlast marks the end of the stream). Bytes are
// buffered; on the 45th byte, or at stream end, one encoded line goes out on
// the rsp_ stream, one character per transaction: length character, four
// characters per group of three bytes, newline. Stream end then adds an empty
// line. rsp_tlast is high on the last character caused by a request.
// Timing: a byte-only request keeps req_tready high. A request that completes
// a line is followed by 2 + 4*ceil(n/3) characters (62 for a full line) at
// one per cycle while rsp_tready is high; the line buffer memory port and the
// single output register set this pace. During emission req_tready is low; it
// returns high after the newline is loaded.
// Stall: a low rsp_tready holds the output register and freezes the line.
// Reset: fill count and totals clear, no result pending; the buffer
// contents are not cleared and need no clearing pass.
`default_nettype none

module uuencode_line_encoder
   import ule_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,  // [7:0] data_byte
   input  wire logic                  req_tuser,  // [0] has_byte
   input  wire logic                  req_tlast,  // stream_end
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // [6:0] out_char, [38:7] char_total,
                                                  // [70:39] line_total, [71] zero
   output logic                       rsp_tlast   // last_of_run
);

   ule_cmd_type    cmd;
   ule_status_type status;

   // sequencing
   ule_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .has_byte   (req_tuser),
      .stream_end (req_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   // buffer, encoding and output
   ule_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .data_byte  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: sv/ule_ctrl.sv
// uuencode line encoder: controller state machine sequencing one line at a time
// depends on ule_pkg; drives the datapath through ule_cmd_type
`default_nettype none

module ule_ctrl
   import ule_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic           has_byte,
   input  wire logic           stream_end,
   input  wire ule_status_type status,
   output ule_cmd_type         cmd
);

   ule_state_type state_ff, state_in;
   logic          end_pend_ff, end_pend_in;

   // state and pending end-of-stream flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         end_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         end_pend_ff <= end_pend_in;
      end
   end

   // next state and commands
   always_comb begin
      logic full;
      logic nz_after;
      full        = has_byte && status.fill_top;
      nz_after    = has_byte || status.fill_nz;
      state_in    = state_ff;
      end_pend_in = end_pend_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      cmd.len_sel = LEN_ZERO;
      cmd.chr_sel = CHR_LEN;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.store = has_byte;
               if (full) begin
                  cmd.len_load   = 1'b1;
                  cmd.len_sel    = LEN_FULL;
                  cmd.fill_clear = 1'b1;
                  end_pend_in    = stream_end;
                  state_in       = ST_LEN;
               end else if (stream_end) begin
                  cmd.len_load   = 1'b1;
                  cmd.len_sel    = nz_after ? LEN_FILL : LEN_ZERO;
                  cmd.fill_clear = 1'b1;
                  end_pend_in    = nz_after;
                  state_in       = ST_LEN;
               end
            end
         end
         ST_LEN: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.chr_sel   = CHR_LEN;
               cmd.grp_start = 1'b1;
               state_in      = status.len_zero ? ST_NL : ST_CH0;
            end
         end
         ST_CH0: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.chr_sel = CHR_S0;
               state_in    = ST_CH1;
            end
         end
         ST_CH1: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.chr_sel = CHR_S1;
               state_in    = ST_CH2;
            end
         end
         ST_CH2: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.chr_sel = CHR_S2;
               state_in    = ST_CH3;
            end
         end
         ST_CH3: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.chr_sel = CHR_S3;
               if (status.last_grp) begin
                  state_in = ST_NL;
               end else begin
                  cmd.grp_next = 1'b1;
                  state_in     = ST_CH0;
               end
            end
         end
         ST_NL: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.chr_sel = CHR_NL;
               cmd.last    = !end_pend_ff;
               if (end_pend_ff) begin
                  // empty line closes the stream
                  cmd.len_load = 1'b1;
                  cmd.len_sel  = LEN_ZERO;
                  end_pend_in  = 1'b0;
                  state_in     = ST_LEN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/ule_datapath.sv
// uuencode line encoder: line buffer, group reader, character mapping,
// output register and saturating totals; depends on ule_pkg
`default_nettype none

module ule_datapath
   import ule_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        data_byte,
   input  wire ule_cmd_type       cmd,
   output ule_status_type         status,
   input  wire logic              rsp_tready,
   output logic                   rsp_tvalid,
   output logic                   rsp_tlast,
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   // line buffer split in three byte lanes, one row per group
   logic [7:0] lane0_mem [NGROUPS];
   logic [7:0] lane1_mem [NGROUPS];
   logic [7:0] lane2_mem [NGROUPS];

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [GRP_W-1:0]  fill_grp_ff, fill_grp_in;
   logic [1:0]        fill_lane_ff, fill_lane_in;
   logic [FILL_W-1:0] line_len_ff, line_len_in;
   logic [GRP_W-1:0]  grp_ff, grp_in;
   logic [FILL_W-1:0] left_ff, left_in;
   logic [7:0]        rd0_ff, rd1_ff, rd2_ff;
   logic [6:0]        char_ff;
   logic              last_ff;
   logic              valid_ff, valid_in;
   logic [31:0]       char_total_ff, char_total_in;
   logic [31:0]       line_total_ff, line_total_in;

   logic [FILL_W-1:0] fill_new;
   logic              rd_en;
   logic [GRP_W-1:0]  rd_addr;
   logic [23:0]       group;
   logic [6:0]        char_sel;

   // fill position of the next byte
   always_comb begin
      fill_new     = fill_ff + FILL_W'(cmd.store);
      fill_in      = fill_ff;
      fill_grp_in  = fill_grp_ff;
      fill_lane_in = fill_lane_ff;
      if (cmd.fill_clear) begin
         fill_in      = '0;
         fill_grp_in  = '0;
         fill_lane_in = 2'd0;
      end else if (cmd.store) begin
         fill_in = fill_new;
         if (fill_lane_ff == 2'd2) begin
            fill_lane_in = 2'd0;
            fill_grp_in  = fill_grp_ff + GRP_W'(1);
         end else begin
            fill_lane_in = fill_lane_ff + 2'd1;
         end
      end
   end

   // line length and group walk
   always_comb begin
      line_len_in = line_len_ff;
      if (cmd.len_load) begin
         case (cmd.len_sel)
            LEN_FULL: line_len_in = FILL_W'(LINE_BYTES);
            LEN_FILL: line_len_in = fill_new;
            default:  line_len_in = '0;
         endcase
      end
      grp_in  = grp_ff;
      left_in = left_ff;
      if (cmd.grp_start) begin
         grp_in  = '0;
         left_in = line_len_ff;
      end else if (cmd.grp_next) begin
         grp_in  = grp_ff + GRP_W'(1);
         left_in = left_ff - FILL_W'(3);
      end
      rd_en   = cmd.grp_start || cmd.grp_next;
      rd_addr = cmd.grp_start ? '0 : (grp_ff + GRP_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         fill_grp_ff  <= '0;
         fill_lane_ff <= 2'd0;
      end else begin
         fill_ff      <= fill_in;
         fill_grp_ff  <= fill_grp_in;
         fill_lane_ff <= fill_lane_in;
      end
   end

   always_ff @(posedge clock) begin
      line_len_ff <= line_len_in;
      grp_ff      <= grp_in;
      left_ff     <= left_in;
   end

   // buffer write on store, registered group read
   always_ff @(posedge clock) begin
      if (cmd.store && fill_lane_ff == 2'd0) lane0_mem[fill_grp_ff] <= data_byte;
      if (cmd.store && fill_lane_ff == 2'd1) lane1_mem[fill_grp_ff] <= data_byte;
      if (cmd.store && fill_lane_ff == 2'd2) lane2_mem[fill_grp_ff] <= data_byte;
      if (rd_en) begin
         rd0_ff <= lane0_mem[rd_addr];
         rd1_ff <= lane1_mem[rd_addr];
         rd2_ff <= lane2_mem[rd_addr];
      end
   end

   // bytes past the line end read as zero
   always_comb begin
      group = {rd0_ff,
               (left_ff >= FILL_W'(2)) ? rd1_ff : 8'h00,
               (left_ff >= FILL_W'(3)) ? rd2_ff : 8'h00};
      case (cmd.chr_sel)
         CHR_LEN: char_sel = to_printable(line_len_ff[5:0]);
         CHR_S0:  char_sel = to_printable(group[23:18]);
         CHR_S1:  char_sel = to_printable(group[17:12]);
         CHR_S2:  char_sel = to_printable(group[11:6]);
         CHR_S3:  char_sel = to_printable(group[5:0]);
         default: char_sel = NEWLINE_CHAR;
      endcase
   end

   // output register and saturating totals
   always_comb begin
      valid_in      = valid_ff && !rsp_tready;
      char_total_in = char_total_ff;
      line_total_in = line_total_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         if (char_total_ff != '1) char_total_in = char_total_ff + 32'd1;
         if (cmd.chr_sel == CHR_NL && line_total_ff != '1) begin
            line_total_in = line_total_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         char_total_ff <= '0;
         line_total_ff <= '0;
      end else begin
         valid_ff      <= valid_in;
         char_total_ff <= char_total_in;
         line_total_ff <= line_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         char_ff <= char_sel;
         last_ff <= cmd.last;
      end
   end

   // status toward the controller
   always_comb begin
      status.out_free = !valid_ff || rsp_tready;
      status.fill_top = (fill_ff == FILL_W'(LINE_BYTES - 1));
      status.fill_nz  = (fill_ff != '0);
      status.len_zero = (line_len_ff == '0);
      status.last_grp = (left_ff <= FILL_W'(3));
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {1'b0, line_total_ff, char_total_ff, char_ff};

endmodule

`default_nettype wire

FILE: sv/ule_checker.sv
// uuencode line encoder: port-level checker and its bind to the top level
// depends on ule_pkg and uuencode_line_encoder_defines.svh
`default_nettype none
`include "uuencode_line_encoder_defines.svh"

module ule_checker
   import ule_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  req_tlast,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast
);

   logic [6:0]          rsp_char;
   logic [RSP_DATA_W:0] rsp_word;
   logic                rsp_stall;
   logic                char_ok;
   logic                end_accept;

   assign rsp_char   = rsp_tdata[6:0];
   assign rsp_word   = {rsp_tlast, rsp_tdata};
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign char_ok    = (rsp_char == NEWLINE_CHAR) ||
                       (rsp_char > SPACE_CHAR && rsp_char <= ZERO_CHAR);
   assign end_accept = req_tvalid && req_tready && req_tlast;

   // a stalled result keeps its payload
   `ULE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // every character is a newline or lies in the printable range
   `ULE_ASSERT_IMP(a_char_range, clock, reset, rsp_tvalid, char_ok)

   // a run always closes on a newline
   `ULE_ASSERT_IMP(a_last_on_newline, clock, reset, rsp_tvalid && rsp_tlast, rsp_char == NEWLINE_CHAR)

   // pad bit of the result bus stays zero
   `ULE_ASSERT_IMP(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[RSP_DATA_W-1] == 1'b0)

   // a stream end always produces output, so the input closes right after it
   `ULE_ASSERT_NEXT(a_end_blocks_input, clock, reset, end_accept, !req_tready)

endmodule

bind uuencode_line_encoder ule_checker u_ule_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
// uuencode line encoder testbench: directed and random byte streams with
// a self-checking predictor of the encoded text; depends on ule_pkg and the RTL
`default_nettype none

module tb_top
   import ule_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // worst case ~330 requests, each with up to 64 characters under sink stalls
   // plus a sender gap; the limit leaves plenty of margin on top of that
   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned TARGET_ITEMS = 310;
   localparam int unsigned SETTLE_CYCLES = 100;
   localparam int unsigned MAX_REPORTS  = 10;

   // how a stream of bytes is closed
   typedef enum logic [1:0] {
      CLOSE_ON_LAST,   // stream end rides on the last byte
      CLOSE_SEPARATE,  // end-only request after the bytes
      CLOSE_NONE       // no end; the next stream continues the line
   } close_mode_type;

   // one expected character transaction
   typedef struct packed {
      logic [6:0]  code;
      logic        last;
      logic [31:0] chars;
      logic [31:0] lines;
   } enc_char_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'h00;
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // predictor state
   logic [7:0]   line_buf [LINE_BYTES];
   int unsigned  fill_level = 0;
   logic [31:0]  chars_sent = '0;
   logic [31:0]  lines_sent = '0;
   int unsigned  run_chars;
   enc_char_type expected_chars [$];

   // run bookkeeping
   int unsigned requests_sent = 0;
   int unsigned idle_sent = 0;
   int unsigned chars_checked = 0;
   int unsigned lines_checked = 0;
   int unsigned mismatch_count = 0;
   bit          sender_gaps_on = 1'b1;
   bit          sink_stalls_on = 1'b1;

   uuencode_line_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   // six-bit value to its printable character
   function automatic logic [6:0] sextet_char(input logic [5:0] v);
      if (v == 6'd0) return ZERO_CHAR;
      return SPACE_CHAR + {1'b0, v};
   endfunction

   function automatic logic [31:0] bump_total(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // idle cycles before the next request: mostly none, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!sender_gaps_on || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   task automatic push_char(input logic [6:0] code);
      enc_char_type c;
      chars_sent = bump_total(chars_sent);
      if (code == NEWLINE_CHAR) lines_sent = bump_total(lines_sent);
      c.code  = code;
      c.last  = 1'b0;
      c.chars = chars_sent;
      c.lines = lines_sent;
      expected_chars.push_back(c);
      run_chars++;
   endtask

   // length char, four chars per group of three, newline
   task automatic push_line(input int unsigned nbytes);
      logic [7:0] b0, b1, b2;
      push_char(sextet_char(nbytes[5:0]));
      for (int unsigned i = 0; i < nbytes; i += 3) begin
         b0 = line_buf[i];
         b1 = (i + 1 < nbytes) ? line_buf[i + 1] : 8'h00;
         b2 = (i + 2 < nbytes) ? line_buf[i + 2] : 8'h00;
         push_char(sextet_char(b0[7:2]));
         push_char(sextet_char({b0[1:0], b1[7:4]}));
         push_char(sextet_char({b1[3:0], b2[7:6]}));
         push_char(sextet_char(b2[5:0]));
      end
      push_char(NEWLINE_CHAR);
   endtask

   // expected characters for one accepted request
   task automatic predict_encoding(input logic [7:0] data, input logic has_byte,
                                   input logic stream_end);
      run_chars = 0;
      if (has_byte) begin
         line_buf[fill_level] = data;
         fill_level++;
         if (fill_level == LINE_BYTES) begin
            push_line(LINE_BYTES);
            fill_level = 0;
         end
      end
      if (stream_end) begin
         if (fill_level > 0) push_line(fill_level);
         fill_level = 0;
         push_line(0);
      end
      if (run_chars > 0) expected_chars[expected_chars.size() - 1].last = 1'b1;
   endtask

   // drive one request at the falling edge and hold it until accepted
   task automatic send_request(input logic [7:0] data, input logic has_byte,
                               input logic stream_end);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= has_byte;
      req_tlast  <= stream_end;
      do @(posedge clock); while (!req_tready);
      predict_encoding(data, has_byte, stream_end);
      if (has_byte || stream_end) requests_sent++;
      else idle_sent++;
   endtask

   // random bytes with stray idle requests, then the chosen close
   task automatic send_stream(input int unsigned nbytes, input close_mode_type mode);
      for (int unsigned i = 0; i < nbytes; i++) begin
         if ($urandom_range(0, 99) < 8)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_request(8'($urandom_range(0, 255)), 1'b1,
                      (mode == CLOSE_ON_LAST) && (i == nbytes - 1));
      end
      if (mode == CLOSE_SEPARATE || (mode == CLOSE_ON_LAST && nbytes == 0))
         send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   function automatic void log_failure(input string what, input enc_char_type want,
                                       input enc_char_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("[%0t] %s: expected char %h last %b chars %0d lines %0d,",
                  $realtime, what, want.code, want.last, want.chars, want.lines);
         $display("   got char %h last %b chars %0d lines %0d",
                  got.code, got.last, got.chars, got.lines);
      end
   endfunction

   // sink back-pressure: stalls of random length, or none while disabled
   initial begin
      int unsigned hold;
      forever begin
         @(negedge clock);
         if (!sink_stalls_on || $urandom_range(0, 99) < 75) begin
            rsp_tready <= 1'b1;
         end else begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 2);
            rsp_tready <= 1'b0;
            repeat (hold - 1) @(negedge clock);
         end
      end
   end

   // compare each character transaction with the oldest expectation
   always @(posedge clock) begin
      enc_char_type want;
      enc_char_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.code  = rsp_tdata[6:0];
         got.last  = rsp_tlast;
         got.chars = rsp_tdata[38:7];
         got.lines = rsp_tdata[70:39];
         if (expected_chars.size() == 0) begin
            want = '0;
            log_failure("unexpected character", want, got);
         end else begin
            want = expected_chars.pop_front();
            if (got !== want) log_failure("character mismatch", want, got);
            chars_checked++;
            if (want.code == NEWLINE_CHAR) lines_checked++;
         end
      end
   end

   // idle requests and a stream end with nothing buffered
   task automatic test_idle_and_empty_end();
      send_request(8'h00, 1'b0, 1'b0);
      send_request(8'hA5, 1'b0, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);
   endtask

   // one, two and three byte lines: missing bytes read as zero
   task automatic test_short_groups();
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'hFF, 1'b1, 1'b1);
      send_request(8'hFF, 1'b1, 1'b0);
      send_request(8'h80, 1'b1, 1'b0);
      send_request(8'h00, 1'b0, 1'b0);
      send_request(8'h7E, 1'b0, 1'b1);
      // sender holds off until the encoder has emptied its output
      drain_results();
      send_request(8'h55, 1'b1, 1'b0);
      send_request(8'hAA, 1'b1, 1'b0);
      send_request(8'h0F, 1'b1, 1'b1);
   endtask

   // walking ones then an end-only request whose data must be ignored
   task automatic test_new_stream_after_end();
      for (int i = 0; i < 7; i++) send_request(8'(1 << i), 1'b1, 1'b0);
      send_request(8'hC3, 1'b0, 1'b1);
   endtask

   // full lines: end on the 45th byte, a full line followed by an end, and a stream one byte short of two lines
   task automatic test_full_lines();
      send_stream(LINE_BYTES, CLOSE_ON_LAST);
      send_stream(LINE_BYTES, CLOSE_SEPARATE);
      send_stream(2 * LINE_BYTES - 1, CLOSE_ON_LAST);
   endtask

   // random streams, mostly short, some spanning several lines
   task automatic test_random_streams();
      int unsigned r;
      int unsigned nbytes;
      int unsigned budget;
      close_mode_type mode;
      while (requests_sent + idle_sent < TARGET_ITEMS) begin
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         sink_stalls_on = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 99);
         if (r < 60) nbytes = $urandom_range(0, 12);
         else if (r < 80) nbytes = $urandom_range(13, 50);
         else if (r < 90) nbytes = $urandom_range(51, 100);
         else nbytes = ($urandom_range(0, 1) != 0) ? LINE_BYTES : 2 * LINE_BYTES;
         // keep the total close to the item target
         budget = TARGET_ITEMS - requests_sent - idle_sent;
         if (nbytes > budget) nbytes = budget;
         r = $urandom_range(0, 99);
         if (r < 45) mode = CLOSE_ON_LAST;
         else if (r < 85) mode = CLOSE_SEPARATE;
         else mode = CLOSE_NONE;
         send_stream(nbytes, mode);
         // occasional run of back-to-back end-only requests
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
      // close whatever partial line is left
      send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_idle_and_empty_end();
      test_short_groups();
      test_new_stream_after_end();
      test_full_lines();
      test_random_streams();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d byte/end requests and %0d idle requests", requests_sent, idle_sent);
      $display("checked %0d characters in %0d encoded lines", chars_checked, lines_checked);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("mismatches: %0d, characters still expected: %0d",
                  mismatch_count, expected_chars.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
